@@ rtl/core/arp_pkg.sv @@
package arp_pkg;

	localparam int CACHE_ENTRIES   = 16;
	localparam int PENDING_ENTRIES = 8;
	localparam int PORT_COUNT      = 4;

	localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int PIDX_W = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
	localparam int CNT_W  = (CIDX_W > PIDX_W) ? CIDX_W : PIDX_W;

	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int PORT_W = 2;
	localparam int TIME_W = 32;
	localparam int LIFE_W = 16;
	localparam int RSND_W = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd15;
	localparam logic [RSND_W-1:0] RESEND_RESET   = 8'd5;
	localparam logic [TIME_W-1:0] SIGN_BIT       = 32'h8000_0000;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_LEARN  = 2'd2,
		CMD_NONE   = 2'd3
	} item_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENTRY_LIFETIME  = 1'b0,
		REG_RESEND_INTERVAL = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CSCAN,
		ST_PSCAN,
		ST_UPDATE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             load;
		logic             tick;
		logic             scan_cache;
		logic             scan_pend;
		logic             update;
		logic [CNT_W-1:0] idx;
	} dp_ctrl_t;

endpackage

@@ rtl/core/arp_resolution_table.sv @@
// Channel  Direction  Handshake                Beat contents
// in       input      in_valid / in_stall      cmd, ip_addr, sender_mac, out_port
// out      output     out_valid / out_stall    hit, hit_mac, send_request, request_port,
//                                              release_pending, release_port, pending_full
// cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A tick or an unknown command gives no result and leaves the block idle.
// A lookup or learn shows its result beat after a one-entry-per-cycle scan of the cache table,
// then of the pending table, and then one update.
// An item holds the block, with in_stall high, until its result beat is taken.
// Reset clears the time counter and all valid bits and reloads the configuration defaults.
// While a result beat is stalled, no new input beat is taken.
module arp_resolution_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [31:0]                   ip_addr,
	input  logic [47:0]                   sender_mac,
	input  logic [1:0]                    out_port,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [47:0]                   hit_mac,
	output logic                          send_request,
	output logic [1:0]                    request_port,
	output logic                          release_pending,
	output logic [1:0]                    release_port,
	output logic                          pending_full,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import arp_pkg::*;

	dp_ctrl_t ctl;

	assign cfg_ready = 1'b1;

	arp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	arp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.ip_addr         (ip_addr),
		.sender_mac      (sender_mac),
		.out_port        (out_port),
		.hit             (hit),
		.hit_mac         (hit_mac),
		.send_request    (send_request),
		.request_port    (request_port),
		.release_pending (release_pending),
		.release_port    (release_port),
		.pending_full    (pending_full)
	);

endmodule

@@ rtl/core/arp_ctrl.sv @@
module arp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        cmd,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output arp_pkg::dp_ctrl_t ctl
);
	import arp_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             c_last, p_last;

	assign accept = in_valid && !in_stall;
	assign c_last = (cnt_q == CNT_W'(CACHE_ENTRIES - 1));
	assign p_last = (cnt_q == CNT_W'(PENDING_ENTRIES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_LOOKUP || cmd == CMD_LEARN)) state_d = ST_CSCAN;
			end
			ST_CSCAN: begin
				if (c_last) state_d = ST_PSCAN;
			end
			ST_PSCAN: begin
				if (p_last) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		out_valid      = (state_q == ST_OUT);
		ctl.load       = accept && (cmd == CMD_LOOKUP || cmd == CMD_LEARN);
		ctl.tick       = accept && (cmd == CMD_TICK);
		ctl.scan_cache = (state_q == ST_CSCAN);
		ctl.scan_pend  = (state_q == ST_PSCAN);
		ctl.update     = (state_q == ST_UPDATE);
		ctl.idx        = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_CSCAN && c_last) || state_q == ST_IDLE) cnt_q <= '0;
			else if (state_q == ST_CSCAN || state_q == ST_PSCAN) cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

@@ rtl/core/arp_dp.sv @@
module arp_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  arp_pkg::dp_ctrl_t            ctl,
	input  logic                         cfg_we,
	input  logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic [1:0]                   cmd,
	input  logic [31:0]                  ip_addr,
	input  logic [47:0]                  sender_mac,
	input  logic [1:0]                   out_port,
	output logic                         hit,
	output logic [47:0]                  hit_mac,
	output logic                         send_request,
	output logic [1:0]                   request_port,
	output logic                         release_pending,
	output logic [1:0]                   release_port,
	output logic                         pending_full
);
	import arp_pkg::*;

	logic [LIFE_W-1:0] lifetime_q;
	logic [RSND_W-1:0] resend_q;
	logic [TIME_W-1:0] now_q;

	logic [1:0]        cmd_q;
	logic [IP_W-1:0]   ip_q;
	logic [MAC_W-1:0]  mac_q;
	logic [PORT_W-1:0] port_q;

	logic [CACHE_ENTRIES-1:0] cvalid_q;
	logic [IP_W-1:0]   cip_q  [CACHE_ENTRIES];
	logic [MAC_W-1:0]  cmac_q [CACHE_ENTRIES];
	logic [TIME_W-1:0] cexp_q [CACHE_ENTRIES];

	logic [PENDING_ENTRIES-1:0] pvalid_q;
	logic [IP_W-1:0]   pip_q   [PENDING_ENTRIES];
	logic [PORT_W-1:0] pport_q [PENDING_ENTRIES];
	logic [TIME_W-1:0] plast_q [PENDING_ENTRIES];

	logic              cfound_q, cfree_found_q;
	logic [CIDX_W-1:0] cidx_q, cfree_q, vict_q;
	logic [MAC_W-1:0]  cmac_hit_q;
	logic [TIME_W-1:0] cexp_hit_q, vkey_q;

	logic              pfound_q, pfree_found_q;
	logic [PIDX_W-1:0] pidx_q, pfree_q;
	logic [PORT_W-1:0] pport_hit_q;
	logic [TIME_W-1:0] plast_hit_q;

	logic [CIDX_W-1:0] ci;
	logic [PIDX_W-1:0] pi;
	logic [TIME_W-1:0] ckey, remain, since;
	logic [CIDX_W-1:0] learn_idx;
	logic              port_ok, unexpired, resend_due;

	assign ci         = ctl.idx[CIDX_W-1:0];
	assign pi         = ctl.idx[PIDX_W-1:0];
	assign ckey       = (cexp_q[ci] - now_q) ^ SIGN_BIT;
	assign remain     = cexp_hit_q - now_q;
	assign since      = now_q - plast_hit_q;
	assign port_ok    = ({{(32-PORT_W){1'b0}}, port_q} < 32'(PORT_COUNT));
	assign unexpired  = cfound_q && !remain[TIME_W-1];
	assign resend_due = (since > {{(TIME_W-RSND_W){1'b0}}, resend_q});
	assign learn_idx  = cfound_q ? cidx_q : (cfree_found_q ? cfree_q : vict_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RESET;
			resend_q   <= RESEND_RESET;
			now_q      <= '0;
			cvalid_q   <= '0;
			pvalid_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ENTRY_LIFETIME:  lifetime_q <= cfg_data[LIFE_W-1:0];
					REG_RESEND_INTERVAL: resend_q   <= cfg_data[RSND_W-1:0];
					default: ;
				endcase
			end
			if (ctl.tick) now_q <= now_q + 1'b1;
			if (ctl.update) begin
				if (cmd_q == CMD_LEARN) begin
					cvalid_q[learn_idx] <= 1'b1;
					if (pfound_q) pvalid_q[pidx_q] <= 1'b0;
				end else if (port_ok && !unexpired && !pfound_q && pfree_found_q) begin
					pvalid_q[pfree_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q         <= cmd;
			ip_q          <= ip_addr;
			mac_q         <= sender_mac;
			port_q        <= out_port;
			cfound_q      <= 1'b0;
			cfree_found_q <= 1'b0;
			vict_q        <= '0;
			vkey_q        <= '1;
			pfound_q      <= 1'b0;
			pfree_found_q <= 1'b0;
		end
		if (ctl.scan_cache) begin
			if (cvalid_q[ci]) begin
				if (!cfound_q && cip_q[ci] == ip_q) begin
					cfound_q   <= 1'b1;
					cidx_q     <= ci;
					cmac_hit_q <= cmac_q[ci];
					cexp_hit_q <= cexp_q[ci];
				end
				if (ckey < vkey_q) begin
					vkey_q <= ckey;
					vict_q <= ci;
				end
			end else if (!cfree_found_q) begin
				cfree_found_q <= 1'b1;
				cfree_q       <= ci;
			end
		end
		if (ctl.scan_pend) begin
			if (pvalid_q[pi]) begin
				if (!pfound_q && pip_q[pi] == ip_q) begin
					pfound_q    <= 1'b1;
					pidx_q      <= pi;
					pport_hit_q <= pport_q[pi];
					plast_hit_q <= plast_q[pi];
				end
			end else if (!pfree_found_q) begin
				pfree_found_q <= 1'b1;
				pfree_q       <= pi;
			end
		end
		if (ctl.update) begin
			hit             <= 1'b0;
			hit_mac         <= '0;
			send_request    <= 1'b0;
			request_port    <= '0;
			release_pending <= 1'b0;
			release_port    <= '0;
			pending_full    <= 1'b0;
			if (cmd_q == CMD_LEARN) begin
				cip_q[learn_idx]  <= ip_q;
				cmac_q[learn_idx] <= mac_q;
				cexp_q[learn_idx] <= now_q + {{(TIME_W-LIFE_W){1'b0}}, lifetime_q};
				if (pfound_q) begin
					release_pending <= 1'b1;
					release_port    <= pport_hit_q;
				end
			end else if (port_ok) begin
				if (unexpired) begin
					hit     <= 1'b1;
					hit_mac <= cmac_hit_q;
				end else if (pfound_q) begin
					if (resend_due) begin
						plast_q[pidx_q] <= now_q;
						send_request    <= 1'b1;
						request_port    <= pport_hit_q;
					end
				end else if (pfree_found_q) begin
					pip_q[pfree_q]   <= ip_q;
					pport_q[pfree_q] <= port_q;
					plast_q[pfree_q] <= now_q;
					send_request     <= 1'b1;
					request_port     <= port_q;
				end else begin
					pending_full <= 1'b1;
				end
			end
		end
	end

endmodule
